// ===== hdl/smpq_pkg.sv =====
package smpq_pkg;

  // Default number of entries held by the queue.
  localparam int CAPACITY_DEF = 16;

  // Operation codes on the input channel.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes on the result channel.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               push_en;
    logic               pop_en;
    logic signed [31:0] value;
  } smpq_cmd_t;

  // One result item on its way to the output buffer.
  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] smallest_value;
    logic               is_empty;
    logic [1:0]         status;
  } smpq_result_t;

endpackage

// ===== hdl/smpq_if.sv =====
// Input channel: one push or pop request per item.
interface smpq_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// Result channel: one result per input item.
interface smpq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic signed [31:0] smallest_value;
  logic               is_empty;
  logic [1:0]         status;

  modport source (output valid, output popped_value, output smallest_value,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input popped_value, input smallest_value,
                  input is_empty, input status, output ready);
endinterface

// ===== hdl/smpq_cell.sv =====
module smpq_cell
  import smpq_pkg::*;
(
  input  logic               clk,
  input  smpq_cmd_t          cmd,
  input  logic               occupied,
  input  logic               prev_le,
  input  logic signed [31:0] prev_value,
  input  logic signed [31:0] next_value,
  output logic               le,
  output logic signed [31:0] value_r
);

  logic signed [31:0] value_nxt;

  // An occupied cell whose entry is not above the new value stays in place.
  assign le = occupied && (value_r <= cmd.value);

  // Push: hold, take the new value at the insert point, or shift up by one.
  // Pop: shift down by one.
  always_comb begin
    value_nxt = value_r;
    if (cmd.push_en) begin
      if (!le) begin
        value_nxt = prev_le ? cmd.value : prev_value;
      end
    end else if (cmd.pop_en) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== hdl/smpq_out_buf.sv =====
module smpq_out_buf
  import smpq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         res_load,
  input  smpq_result_t res,
  output logic         res_ready,
  smpq_out_if.source   out_ch
);

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  smpq_result_t main_r, main_nxt;
  smpq_result_t skid_r, skid_nxt;
  logic         take;

  assign take      = main_valid_r && out_ch.ready;
  assign res_ready = !skid_valid_r;

  // Main register feeds the port; the skid register catches an item
  // that arrives while the main one is stalled.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (res_load) begin
      if (!main_valid_r || take) begin
        main_nxt       = res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid          = main_valid_r;
  assign out_ch.popped_value   = main_r.popped_value;
  assign out_ch.smallest_value = main_r.smallest_value;
  assign out_ch.is_empty       = main_r.is_empty;
  assign out_ch.status         = main_r.status;

endmodule

// ===== hdl/sorted_min_priority_queue_unit.sv =====
// Sorted min-priority queue of signed 32-bit values.
// The input channel carries one item per request: op selects push or pop,
// value is the number to insert on a push. A push places its value after
// any equal entries; a pop removes and returns the smallest entry.
// Each item gives exactly one result item: the popped value (zero unless a
// pop succeeded), the smallest entry held afterwards (zero when empty),
// an empty flag and a status (ok, pop on empty, push on full).
// The entries sit in a chain of CAPACITY cells, each comparing its entry
// with the incoming value in parallel and shifting with its neighbors, so
// one item is taken every cycle while the output buffer has room; the cell
// update is the only step per item, and each result is then registered.
// When the receiver stalls, a two-entry output buffer keeps results and the
// input stays ready until both entries are full.
// Reset empties the queue and the output buffer; no clearing pass is run.
module sorted_min_priority_queue_unit
  import smpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  smpq_in_if.sink    in_ch,
  smpq_out_if.source out_ch
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]      count_r, count_nxt;
  logic               accept;
  logic               full, empty;
  logic               res_ready;
  smpq_cmd_t          cmd;
  smpq_result_t       res;
  logic               le        [CAPACITY];
  logic               occupied  [CAPACITY];
  logic signed [31:0] entry     [CAPACITY];

  assign in_ch.ready = res_ready;
  assign accept      = in_ch.valid && res_ready;
  assign full        = (count_r == CW'(CAPACITY));
  assign empty       = (count_r == '0);

  // Broadcast command to the cells.
  assign cmd.push_en = accept && (in_ch.op == OP_PUSH) && !full;
  assign cmd.pop_en  = accept && (in_ch.op == OP_POP) && !empty;
  assign cmd.value   = in_ch.value;

  // Chain of cells, entry 0 holding the smallest value.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               p_le;
    logic signed [31:0] p_value;
    logic signed [31:0] n_value;

    assign occupied[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign p_le    = 1'b0;
      assign p_value = in_ch.value;
    end else begin : g_mid
      assign p_le    = le[i-1];
      assign p_value = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_value = '0;
    end else begin : g_inner
      assign n_value = entry[i+1];
    end

    smpq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (occupied[i]),
      .prev_le    (p_le),
      .prev_value (p_value),
      .next_value (n_value),
      .le         (le[i]),
      .value_r    (entry[i])
    );
  end

  // Entry count.
  always_comb begin
    count_nxt = count_r;
    if (cmd.push_en) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Result item, formed from the state as it will be after this item.
  always_comb begin
    res.popped_value   = cmd.pop_en ? entry[0] : '0;
    res.is_empty       = (count_nxt == '0);
    res.smallest_value = entry[0];
    if (cmd.push_en) begin
      res.smallest_value = le[0] ? entry[0] : in_ch.value;
    end else if (cmd.pop_en) begin
      res.smallest_value = entry[1];
    end
    if (res.is_empty) begin
      res.smallest_value = '0;
    end
    res.status = ST_OK;
    if (in_ch.op == OP_POP && empty) begin
      res.status = ST_UNDERFLOW;
    end else if (in_ch.op == OP_PUSH && full) begin
      res.status = ST_OVERFLOW;
    end
  end

  smpq_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (accept),
    .res       (res),
    .res_ready (res_ready),
    .out_ch    (out_ch)
  );

endmodule

// ===== hdl/smpq_checker.sv =====
module smpq_checker
  import smpq_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_popped_value,
  input logic signed [31:0] out_smallest_value,
  input logic               out_is_empty,
  input logic [1:0]         out_status
);

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // An empty queue reports zero as its smallest entry.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_smallest_value == '0)
    else $error("empty queue with nonzero smallest value");

  // A refused item never returns a popped value.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_popped_value == '0)
    else $error("refused item returned a popped value");

  // Underflow leaves the queue empty; overflow leaves it nonempty.
  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDERFLOW |-> out_is_empty)
    else $error("underflow on a nonempty queue");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> !out_is_empty)
    else $error("overflow on an empty queue");

endmodule

bind sorted_min_priority_queue_unit smpq_checker u_smpq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_popped_value   (out_ch.popped_value),
  .out_smallest_value (out_ch.smallest_value),
  .out_is_empty       (out_ch.is_empty),
  .out_status         (out_ch.status)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import smpq_pkg::*;

  localparam int QUEUE_DEPTH = CAPACITY_DEF;
  localparam int IDLE_LIMIT  = 4000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 900;

  // One queued request for the driver; a pause entry carries no item.
  typedef struct {
    logic               op;
    logic signed [31:0] value;
    bit                 pause_until_drained;
  } queue_request_t;

  logic clk = 1'b0;
  logic rst_n;

  smpq_in_if  in_ch ();
  smpq_out_if out_ch ();

  sorted_min_priority_queue_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  queue_request_t     pending_requests[$];
  smpq_result_t       expected_results[$];
  logic signed [31:0] held_entries[$];
  int                 request_total = 0;
  int                 items_in = 0;
  int                 items_out = 0;
  int                 fail_count = 0;
  int                 idle_cycles = 0;

  // Driver pacing state.
  int                 burst_left = 1;
  int                 gap_left = 0;
  logic               next_valid;
  bit                 drained;
  queue_request_t     head_request;

  // Receiver pacing state.
  logic [15:0]        ready_pattern = 16'hffff;
  int                 ready_cycle = 0;

  // Apply one push or pop to the local copy of the queue and give its result.
  function automatic smpq_result_t apply_queue_op(input logic op,
                                                  input logic signed [31:0] value);
    smpq_result_t res;
    int           pos;
    res = '0;
    res.status = ST_OK;
    if (op == OP_PUSH) begin
      if (held_entries.size() >= QUEUE_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        // Equal values go behind the ones already held.
        pos = 0;
        while (pos < held_entries.size() && held_entries[pos] <= value) pos++;
        held_entries.insert(pos, value);
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.popped_value = held_entries.pop_front();
      end
    end
    res.smallest_value = (held_entries.size() != 0) ? held_entries[0] : '0;
    res.is_empty       = (held_entries.size() == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    $display("mismatch in %s of result %0d: expected %0d, got %0d",
             field, items_out, want, got);
    fail_count++;
  endtask

  task automatic add_request(input logic op, input logic signed [31:0] value);
    queue_request_t req;
    req.op = op;
    req.value = value;
    req.pause_until_drained = 1'b0;
    pending_requests.push_back(req);
    request_total++;
  endtask

  task automatic add_drain_pause();
    queue_request_t req;
    req.op = OP_PUSH;
    req.value = '0;
    req.pause_until_drained = 1'b1;
    pending_requests.push_back(req);
  endtask

  // Value mix: full range, a narrow band for duplicates, extremes and single bits.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      4, 5, 6: v = $urandom_range(0, 8) - 4;
      7: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = '0;
          default: v = -1;
        endcase
      end
      8: v = ($urandom_range(0, 1) != 0) ? (32'sd1 << $urandom_range(0, 31))
                                         : ~(32'sd1 << $urandom_range(0, 31));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Stimulus, reset and end of run.
  initial begin
    int produced;
    int run_len;
    int push_pct;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PUSH;
    in_ch.value = '0;
    out_ch.ready = 1'b0;

    // Directed part: pop on empty, fill with extremes and duplicates,
    // push on full, then a few pops.
    add_request(OP_POP, 32'sh1234_5678);
    add_request(OP_PUSH, 32'sh7fff_ffff);
    add_request(OP_PUSH, 32'sh8000_0000);
    add_request(OP_PUSH, -1);
    add_request(OP_PUSH, 0);
    add_request(OP_PUSH, 1);
    add_request(OP_PUSH, 5);
    add_request(OP_PUSH, 5);
    add_request(OP_PUSH, -5);
    for (int i = 0; i < QUEUE_DEPTH - 8; i++) add_request(OP_PUSH, $urandom);
    add_request(OP_PUSH, 32'sh5555_5555);
    add_request(OP_PUSH, 32'sh8000_0000);
    for (int i = 0; i < 3; i++) add_request(OP_POP, $urandom);
    add_drain_pause();

    // Random part: runs that lean toward filling or emptying, so that the
    // queue often reaches full and empty.
    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      run_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < run_len; i++) begin
        if ($urandom_range(1, 100) <= push_pct) add_request(OP_PUSH, pick_value());
        else add_request(OP_POP, $urandom);
      end
      produced += run_len;
      if (produced >= RANDOM_ITEMS / 2 && produced - run_len < RANDOM_ITEMS / 2)
        add_drain_pause();
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to be taken and every result to arrive.
    while (items_in != request_total || items_out != request_total) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Driver: bursts of items separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      next_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) next_valid = 1'b0;
      drained = (items_in + ((in_ch.valid && in_ch.ready) ? 1 : 0)) ==
                (items_out + ((out_ch.valid && out_ch.ready) ? 1 : 0));
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0) begin
          if (pending_requests[0].pause_until_drained) begin
            // Hold off until every result in flight has been taken.
            if (drained) void'(pending_requests.pop_front());
          end else begin
            head_request = pending_requests.pop_front();
            in_ch.op    <= head_request.op;
            in_ch.value <= head_request.value;
            next_valid = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
          end
        end
      end
      in_ch.valid <= next_valid;
    end
  end

  // Receiver: a rotating ready pattern whose density changes every so often.
  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    if (ready_cycle % 97 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hffff;
        1: ready_pattern <= 16'($urandom) | 16'h0001;
        2: ready_pattern <= (16'($urandom) & 16'($urandom)) | 16'h0001;
        default: ready_pattern <= 16'($urandom);
      endcase
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
    end
    out_ch.ready <= (ready_pattern == '0) ? 1'b1 : ready_pattern[0];
  end

  // Monitor: predict on each accepted item, then check each accepted result.
  always @(posedge clk) begin
    smpq_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_queue_op(in_ch.op, in_ch.value));
        items_in <= items_in + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        items_out <= items_out + 1;
        if (expected_results.size() == 0) begin
          $display("result %0d arrived with nothing expected", items_out);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.popped_value !== want.popped_value)
            report_mismatch("popped_value", want.popped_value, out_ch.popped_value);
          if (out_ch.smallest_value !== want.smallest_value)
            report_mismatch("smallest_value", want.smallest_value, out_ch.smallest_value);
          if (out_ch.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(want.is_empty), 32'(out_ch.is_empty));
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_ch.status));
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
